/* rtl/tgad_pkg.sv */
// ---------------------------------------------------------------------------
// tgad_pkg
// Shared types and constants of the TGA byte-stream decoder.
// ---------------------------------------------------------------------------
package tgad_pkg;

   // Header layout (byte offsets into the 18-byte header)
   localparam int unsigned HEADER_BYTES = 18;
   localparam logic [4:0]  HDR_IDX_TYPE     = 5'd2;
   localparam logic [4:0]  HDR_IDX_WIDTH_LO = 5'd12;
   localparam logic [4:0]  HDR_IDX_WIDTH_HI = 5'd13;
   localparam logic [4:0]  HDR_IDX_HEIGHT_LO = 5'd14;
   localparam logic [4:0]  HDR_IDX_HEIGHT_HI = 5'd15;
   localparam logic [4:0]  HDR_IDX_DEPTH    = 5'd16;
   localparam logic [4:0]  HDR_IDX_LAST     = 5'(HEADER_BYTES - 1);

   // Image types and pixel sizes
   localparam logic [7:0] TYPE_RAW   = 8'd2;
   localparam logic [7:0] TYPE_RLE   = 8'd10;
   localparam logic [2:0] BPP_BGR    = 3'd3;
   localparam logic [2:0] BPP_BGRA   = 3'd4;
   localparam logic [7:0] RAW_MAX    = 8'd127;
   localparam logic [7:0] FULL_ALPHA = 8'hFF;

   // Decoder phase
   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_PACKET = 4'b0010,
      PH_PIXEL  = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

   // Result kind
   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_PIXEL  = 2'd1,
      KIND_TRUNC  = 2'd2
   } kind_type;

   // Result status
   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_ZERO_SIZE  = 3'd1,
      ST_BAD_TYPE   = 3'd2,
      ST_BAD_DEPTH  = 3'd3,
      ST_TRUNCATED  = 3'd4
   } status_type;

endpackage

/* rtl/tga_image_stream_decoder.sv */
// ---------------------------------------------------------------------------
// tga_image_stream_decoder
// Decodes a TGA file streamed one byte per transfer into a header report,
// pixel runs (raw or RLE, BGR or BGRA) and a truncation report.
// ---------------------------------------------------------------------------
// Takes one file byte per cycle, with no bubbles, while rsp_stall is low: each byte goes
// into an input register, the header/packet/pixel state update and the result
// are formed combinationally from that register, and the result sits in an output
// register, so a result follows its byte through the input and output registers.
// The longest path is the 16x16 width-by-height product that loads the pixel
// count at the last header byte. A byte produces at most one result: the
// header report after byte 17, one run per completed pixel (an RLE run packet
// comes out as a single run with its repeat count, clipped to the image), or a
// truncation report when end_of_file arrives before the image is complete.
// Every end_of_file byte returns the decoder to its reset state, so files may
// follow each other back to back. An invalid header is reported and the rest
// of that file is dropped.
module tga_image_stream_decoder
   import tgad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // byte input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_file,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_image_width,
   output logic [15:0] rsp_image_height,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic [7:0]  rsp_repeat_res,
   output logic        rsp_last
);

   // input register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_eof_ff;

   // decoder state
   phase_type   phase_ff, phase_in;
   logic [4:0]  header_index_ff, header_index_in;
   logic [7:0]  image_type_ff, image_type_in;
   logic [15:0] width_store_ff, width_store_in;
   logic [15:0] height_store_ff, height_store_in;
   logic [2:0]  bytes_per_pixel_ff, bytes_per_pixel_in;
   logic [31:0] pixels_left_ff, pixels_left_in;
   logic [7:0]  packet_left_ff, packet_left_in;
   logic        packet_is_run_ff, packet_is_run_in;
   logic [1:0]  byte_in_pixel_ff, byte_in_pixel_in;
   logic [23:0] partial_colour_ff, partial_colour_in;

   // result register
   logic        out_valid_ff;
   kind_type    out_kind_ff, res_kind;
   status_type  out_status_ff, res_status;
   logic [15:0] out_width_ff, out_height_ff;
   logic [7:0]  out_red_ff, out_green_ff, out_blue_ff, out_alpha_ff, out_repeat_ff;
   logic        out_last_ff;

   // step results
   logic        res_have;
   logic [7:0]  res_red, res_green, res_blue, res_alpha, res_repeat;
   logic        res_last;
   logic [15:0] res_width, res_height;

   // step helpers
   logic        out_free;
   logic        step_fire;
   logic        is_rle;
   logic [4:0]  depth_bytes;
   logic [31:0] pixel_total;
   logic [23:0] partial_next;
   logic        pixel_done;
   logic [7:0]  run_count;
   logic [7:0]  clip_count;

   // handshake: the step fires when the result register can take its output
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step_fire = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   assign is_rle      = (image_type_ff == TYPE_RLE);
   assign depth_bytes = in_byte_ff[7:3];
   assign pixel_total = width_store_ff * height_store_ff;

   // per-byte state update and result
   always_comb begin
      phase_in           = phase_ff;
      header_index_in    = header_index_ff;
      image_type_in      = image_type_ff;
      width_store_in     = width_store_ff;
      height_store_in    = height_store_ff;
      bytes_per_pixel_in = bytes_per_pixel_ff;
      pixels_left_in     = pixels_left_ff;
      packet_left_in     = packet_left_ff;
      packet_is_run_in   = packet_is_run_ff;
      byte_in_pixel_in   = byte_in_pixel_ff;
      partial_colour_in  = partial_colour_ff;

      res_have   = 1'b0;
      res_kind   = KIND_HEADER;
      res_status = ST_OK;
      res_red    = 8'd0;
      res_green  = 8'd0;
      res_blue   = 8'd0;
      res_alpha  = 8'd0;
      res_repeat = 8'd0;
      res_last   = 1'b0;

      partial_next = partial_colour_ff;
      pixel_done   = 1'b0;
      run_count    = 8'd1;
      clip_count   = 8'd1;

      unique case (phase_ff)
         PH_HEADER: begin
            // capture header fields
            unique case (header_index_ff)
               HDR_IDX_TYPE:      image_type_in = in_byte_ff;
               HDR_IDX_WIDTH_LO:  width_store_in = {width_store_ff[15:8], in_byte_ff};
               HDR_IDX_WIDTH_HI:  width_store_in = {in_byte_ff, width_store_ff[7:0]};
               HDR_IDX_HEIGHT_LO: height_store_in = {height_store_ff[15:8], in_byte_ff};
               HDR_IDX_HEIGHT_HI: height_store_in = {in_byte_ff, height_store_ff[7:0]};
               HDR_IDX_DEPTH: begin
                  if (depth_bytes == 5'(BPP_BGR) || depth_bytes == 5'(BPP_BGRA)) begin
                     bytes_per_pixel_in = depth_bytes[2:0];
                  end else begin
                     bytes_per_pixel_in = 3'd0;
                  end
               end
               default: ;
            endcase

            if (header_index_ff != HDR_IDX_LAST) begin
               header_index_in = header_index_ff + 5'd1;
            end else begin
               // header complete: validate and report
               header_index_in = 5'd0;
               res_have        = 1'b1;
               res_kind        = KIND_HEADER;
               if (width_store_ff == 16'd0 || height_store_ff == 16'd0) begin
                  res_status = ST_ZERO_SIZE;
               end else if (image_type_ff != TYPE_RAW && image_type_ff != TYPE_RLE) begin
                  res_status = ST_BAD_TYPE;
               end else if (bytes_per_pixel_ff == 3'd0) begin
                  res_status = ST_BAD_DEPTH;
               end
               if (res_status != ST_OK) begin
                  phase_in = PH_DONE;
               end else begin
                  pixels_left_in    = pixel_total;
                  byte_in_pixel_in  = 2'd0;
                  packet_left_in    = 8'd0;
                  packet_is_run_in  = 1'b0;
                  partial_colour_in = 24'd0;
                  phase_in          = is_rle ? PH_PACKET : PH_PIXEL;
               end
            end
         end

         PH_PACKET: begin
            // RLE packet header
            if (in_byte_ff > RAW_MAX) begin
               packet_is_run_in = 1'b1;
               packet_left_in   = in_byte_ff - RAW_MAX;
            end else begin
               packet_is_run_in = 1'b0;
               packet_left_in   = in_byte_ff + 8'd1;
            end
            byte_in_pixel_in = 2'd0;
            phase_in         = PH_PIXEL;
         end

         PH_PIXEL: begin
            // gather B, G, R (alpha is taken straight from the byte)
            case (byte_in_pixel_ff)
               2'd0:    partial_next = {16'd0, in_byte_ff};
               2'd1:    partial_next = partial_colour_ff | {8'd0, in_byte_ff, 8'd0};
               2'd2:    partial_next = partial_colour_ff | {in_byte_ff, 16'd0};
               default: partial_next = partial_colour_ff;
            endcase
            partial_colour_in = partial_next;
            pixel_done = ({1'b0, byte_in_pixel_ff} + 3'd1) >= bytes_per_pixel_ff;

            if (!pixel_done) begin
               byte_in_pixel_in = byte_in_pixel_ff + 2'd1;
            end else begin
               byte_in_pixel_in = 2'd0;
               res_blue  = partial_next[7:0];
               res_green = partial_next[15:8];
               res_red   = partial_next[23:16];
               res_alpha = (bytes_per_pixel_ff == BPP_BGRA) ? in_byte_ff : FULL_ALPHA;

               // run length, clipped to the pixels still missing
               run_count = (is_rle && packet_is_run_ff) ? packet_left_ff : 8'd1;
               if ({24'd0, run_count} > pixels_left_ff) begin
                  clip_count = pixels_left_ff[7:0];
               end else begin
                  clip_count = run_count;
               end
               res_repeat     = clip_count;
               pixels_left_in = pixels_left_ff - {24'd0, clip_count};

               if (is_rle) begin
                  if (packet_is_run_ff || packet_left_ff == 8'd0) begin
                     packet_left_in = 8'd0;
                  end else begin
                     packet_left_in = packet_left_ff - 8'd1;
                  end
               end

               res_have = 1'b1;
               res_kind = KIND_PIXEL;
               if (pixels_left_in == 32'd0) begin
                  res_last = 1'b1;
                  phase_in = PH_DONE;
               end else if (is_rle && packet_left_in == 8'd0) begin
                  phase_in = PH_PACKET;
               end
            end
         end

         PH_DONE: ;

         default: ;
      endcase

      // early end of file
      if (in_eof_ff && phase_in != PH_DONE) begin
         res_have   = 1'b1;
         res_kind   = KIND_TRUNC;
         res_status = ST_TRUNCATED;
         res_last   = 1'b0;
      end

      // reported size is taken before the file-end clear
      res_width  = width_store_in;
      res_height = height_store_in;

      // every file end returns to the reset state
      if (in_eof_ff) begin
         phase_in           = PH_HEADER;
         header_index_in    = 5'd0;
         image_type_in      = 8'd0;
         width_store_in     = 16'd0;
         height_store_in    = 16'd0;
         bytes_per_pixel_in = 3'd0;
         pixels_left_in     = 32'd0;
         packet_left_in     = 8'd0;
         packet_is_run_in   = 1'b0;
         byte_in_pixel_in   = 2'd0;
         partial_colour_in  = 24'd0;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!in_valid_ff || out_free) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
         in_eof_ff  <= req_end_of_file;
      end
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_HEADER;
         header_index_ff    <= 5'd0;
         image_type_ff      <= 8'd0;
         width_store_ff     <= 16'd0;
         height_store_ff    <= 16'd0;
         bytes_per_pixel_ff <= 3'd0;
         pixels_left_ff     <= 32'd0;
         packet_left_ff     <= 8'd0;
         packet_is_run_ff   <= 1'b0;
         byte_in_pixel_ff   <= 2'd0;
         partial_colour_ff  <= 24'd0;
      end else if (step_fire) begin
         phase_ff           <= phase_in;
         header_index_ff    <= header_index_in;
         image_type_ff      <= image_type_in;
         width_store_ff     <= width_store_in;
         height_store_ff    <= height_store_in;
         bytes_per_pixel_ff <= bytes_per_pixel_in;
         pixels_left_ff     <= pixels_left_in;
         packet_left_ff     <= packet_left_in;
         packet_is_run_ff   <= packet_is_run_in;
         byte_in_pixel_ff   <= byte_in_pixel_in;
         partial_colour_ff  <= partial_colour_in;
      end
   end

   // result register; reported size is the stored size after this byte
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= step_fire && res_have;
      end
      if (step_fire && res_have) begin
         out_kind_ff   <= res_kind;
         out_status_ff <= res_status;
         out_width_ff  <= res_width;
         out_height_ff <= res_height;
         out_red_ff    <= res_red;
         out_green_ff  <= res_green;
         out_blue_ff   <= res_blue;
         out_alpha_ff  <= res_alpha;
         out_repeat_ff <= res_repeat;
         out_last_ff   <= res_last;
      end
   end

   // width/height in a result come from the store before the file-end clear
   // (a file-end clear never touches a result's own fields)

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_kind_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_image_width  = out_width_ff;
   assign rsp_image_height = out_height_ff;
   assign rsp_red          = out_red_ff;
   assign rsp_green        = out_green_ff;
   assign rsp_blue         = out_blue_ff;
   assign rsp_alpha        = out_alpha_ff;
   assign rsp_repeat_res   = out_repeat_ff;
   assign rsp_last         = out_last_ff;

   // a completed image is only ever flagged on a pixel run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_kind == KIND_PIXEL)
      else $error("last flag on a result that is not a pixel run");

   // a pixel run always covers at least one pixel and reports ok
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_PIXEL |-> rsp_repeat_res != 8'd0 && rsp_status == ST_OK)
      else $error("pixel run with zero repeat or nonzero status");

   // the decoder is back at the header start after every file end
   assert property (@(posedge clock) disable iff (reset)
      step_fire && in_eof_ff |=> phase_ff == PH_HEADER && header_index_ff == 5'd0)
      else $error("decoder not reset after end of file");

endmodule

/* test/tga_image_stream_decoder_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tga_image_stream_decoder_tb
// Streams whole TGA files (valid, faulty, truncated, padded) byte by byte
// into the decoder, predicts every header report, pixel run and truncation
// report, and checks each result transfer in order against the prediction.
// ---------------------------------------------------------------------------
module tga_image_stream_decoder_tb;
   import tgad_pkg::*;

   // One decoder result, as seen on the rsp_ ports
   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  status;
      logic [15:0] width;
      logic [15:0] height;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [7:0]  reps;
      logic        last;
   } tga_report_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_end_of_file;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_image_width;
   logic [15:0] rsp_image_height;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_alpha;
   logic [7:0]  rsp_repeat_res;
   logic        rsp_last;

   // Predicted results not yet seen, oldest first
   tga_report_type pending_reports[$];
   // File under construction
   logic [7:0]  file_bytes[$];
   int          errors = 0;

   // Idle control shared with the receiver process
   bit          sender_gaps = 1'b1;
   bit          receiver_gaps = 1'b1;
   int          hold_request = 0;
   int          hold_served = 0;
   int          hold_count = 0;

   // Decoder state mirror
   phase_type   dec_phase;
   logic [4:0]  hdr_idx;
   logic [7:0]  img_type;
   logic [15:0] w_store;
   logic [15:0] h_store;
   logic [2:0]  bpp;
   logic [31:0] pix_left;
   logic [7:0]  pkt_left;
   logic        pkt_run;
   logic [1:0]  byte_idx;
   logic [23:0] colour;

   tga_image_stream_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_end_of_file  (req_end_of_file),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_status       (rsp_status),
      .rsp_image_width  (rsp_image_width),
      .rsp_image_height (rsp_image_height),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_alpha        (rsp_alpha),
      .rsp_repeat_res   (rsp_repeat_res),
      .rsp_last         (rsp_last)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Decoder prediction
   // ------------------------------------------------------------------
   task automatic clear_decoder();
      dec_phase = PH_HEADER;
      hdr_idx   = '0;
      img_type  = '0;
      w_store   = '0;
      h_store   = '0;
      bpp       = '0;
      pix_left  = '0;
      pkt_left  = '0;
      pkt_run   = 1'b0;
      byte_idx  = '0;
      colour    = '0;
   endtask

   // Advance the mirror by one accepted byte; queue the result it causes
   task automatic decode_byte(input logic [7:0] b, input logic eof);
      tga_report_type r;
      bit          have;
      logic [4:0]  depth_bytes;
      logic [31:0] count;
      r    = '0;
      have = 1'b0;
      case (dec_phase)
         PH_HEADER: begin
            case (hdr_idx)
               HDR_IDX_TYPE:      img_type = b;
               HDR_IDX_WIDTH_LO:  w_store[7:0] = b;
               HDR_IDX_WIDTH_HI:  w_store[15:8] = b;
               HDR_IDX_HEIGHT_LO: h_store[7:0] = b;
               HDR_IDX_HEIGHT_HI: h_store[15:8] = b;
               HDR_IDX_DEPTH: begin
                  depth_bytes = b[7:3];
                  bpp = (depth_bytes == 5'd3) ? BPP_BGR :
                        (depth_bytes == 5'd4) ? BPP_BGRA : 3'd0;
               end
               default: ;
            endcase
            if (hdr_idx != HDR_IDX_LAST) begin
               hdr_idx = hdr_idx + 5'd1;
            end else begin
               hdr_idx = '0;
               // first fault wins: size, then type, then depth
               if (w_store == '0 || h_store == '0)
                  r.status = ST_ZERO_SIZE;
               else if (img_type != TYPE_RAW && img_type != TYPE_RLE)
                  r.status = ST_BAD_TYPE;
               else if (bpp == 3'd0)
                  r.status = ST_BAD_DEPTH;
               else
                  r.status = ST_OK;
               have   = 1'b1;
               r.kind = KIND_HEADER;
               if (r.status != ST_OK) begin
                  dec_phase = PH_DONE;
               end else begin
                  pix_left  = {16'd0, w_store} * {16'd0, h_store};
                  byte_idx  = '0;
                  pkt_left  = '0;
                  pkt_run   = 1'b0;
                  colour    = '0;
                  dec_phase = (img_type == TYPE_RAW) ? PH_PIXEL : PH_PACKET;
               end
            end
         end
         PH_PACKET: begin
            if (b > RAW_MAX) begin
               pkt_run  = 1'b1;
               pkt_left = b - RAW_MAX;
            end else begin
               pkt_run  = 1'b0;
               pkt_left = b + 8'd1;
            end
            byte_idx  = '0;
            dec_phase = PH_PIXEL;
         end
         PH_PIXEL: begin
            // BGR bytes collect into the color word; a fourth byte is alpha
            if (byte_idx == 2'd0)
               colour = {16'd0, b};
            else if (byte_idx != 2'd3)
               colour[8*byte_idx +: 8] = b;
            if (3'(byte_idx) + 3'd1 < bpp) begin
               byte_idx = byte_idx + 2'd1;
            end else begin
               byte_idx = '0;
               r.blue   = colour[7:0];
               r.green  = colour[15:8];
               r.red    = colour[23:16];
               r.alpha  = (bpp == BPP_BGRA) ? b : FULL_ALPHA;
               count = (img_type == TYPE_RLE && pkt_run) ? {24'd0, pkt_left} : 32'd1;
               if (count > pix_left)
                  count = pix_left;
               r.reps   = count[7:0];
               pix_left = pix_left - count;
               if (img_type == TYPE_RLE) begin
                  if (pkt_run || pkt_left == '0)
                     pkt_left = '0;
                  else
                     pkt_left = pkt_left - 8'd1;
               end
               have   = 1'b1;
               r.kind = KIND_PIXEL;
               if (pix_left == '0) begin
                  r.last    = 1'b1;
                  dec_phase = PH_DONE;
               end else if (img_type == TYPE_RLE && pkt_left == '0) begin
                  dec_phase = PH_PACKET;
               end
            end
         end
         default: ;
      endcase
      // early end of file overrides kind and status, keeps color and repeat
      if (eof && dec_phase != PH_DONE) begin
         have     = 1'b1;
         r.kind   = KIND_TRUNC;
         r.status = ST_TRUNCATED;
         r.last   = 1'b0;
      end
      r.width  = w_store;
      r.height = h_store;
      if (have)
         pending_reports = {pending_reports, r};
      if (eof)
         clear_decoder();
   endtask

   function automatic string report_text(input tga_report_type r);
      return $sformatf("kind=%0d status=%0d w=%0d h=%0d rgba=%h/%h/%h/%h rep=%0d last=%0b",
                       r.kind, r.status, r.width, r.height, r.red, r.green, r.blue,
                       r.alpha, r.reps, r.last);
   endfunction

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      tga_report_type seen;
      tga_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.kind   = rsp_kind;
         seen.status = rsp_status;
         seen.width  = rsp_image_width;
         seen.height = rsp_image_height;
         seen.red    = rsp_red;
         seen.green  = rsp_green;
         seen.blue   = rsp_blue;
         seen.alpha  = rsp_alpha;
         seen.reps   = rsp_repeat_res;
         seen.last   = rsp_last;
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected result: %s", $time, report_text(seen));
            errors++;
         end else begin
            want = pending_reports.pop_front();
            if (seen !== want) begin
               $display("%0t: result mismatch, expected %s", $time, report_text(want));
               $display("%0t:                  actual   %s", $time, report_text(seen));
               errors++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random stalls, plus a long hold-off on request
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_request != hold_served) begin
         hold_served = hold_request;
         hold_count  = 200;
      end
      if (hold_count > 0) begin
         hold_count--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= receiver_gaps && ($urandom_range(99) < 10);
      end
   end

   // ------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------
   // Called at a falling edge; returns at the falling edge after the transfer
   task automatic send_byte(input logic [7:0] b, input logic eof);
      if (sender_gaps && $urandom_range(99) < 5) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= b;
      req_end_of_file <= eof;
      do @(posedge clock); while (req_stall);
      decode_byte(b, eof);
      @(negedge clock);
   endtask

   task automatic send_file();
      foreach (file_bytes[i])
         send_byte(file_bytes[i], i == file_bytes.size() - 1);
   endtask

   // Sender pauses until every predicted result has arrived
   task automatic await_results();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // File construction
   // ------------------------------------------------------------------
   task automatic append_byte(input logic [7:0] b);
      file_bytes = {file_bytes, b};
   endtask

   function automatic logic [7:0] pick_byte();
      int sel;
      sel = $urandom_range(9);
      if (sel < 2)
         return 8'h00;
      else if (sel < 4)
         return 8'hFF;
      return 8'($urandom_range(255));
   endfunction

   // ID, color-map and descriptor bytes are random: the decoder ignores them
   task automatic build_header(input logic [7:0] kind_byte, input logic [15:0] w,
                               input logic [15:0] h, input logic [7:0] depth);
      file_bytes.delete();
      append_byte(8'($urandom_range(255)));
      append_byte(8'($urandom_range(255)));
      append_byte(kind_byte);
      repeat (9) append_byte(8'($urandom_range(255)));
      append_byte(w[7:0]);
      append_byte(w[15:8]);
      append_byte(h[7:0]);
      append_byte(h[15:8]);
      append_byte(depth);
      append_byte(8'($urandom_range(255)));
   endtask

   task automatic add_pixels(input int count, input int nbytes);
      repeat (count * nbytes) append_byte(pick_byte());
   endtask

   task automatic add_junk(input int count);
      repeat (count) append_byte(8'($urandom_range(255)));
   endtask

   // Random mix of run and raw packets; counts may overshoot the image
   task automatic add_rle_packets(input int total, input int nbytes);
      int left;
      int n;
      left = total;
      while (left > 0) begin
         if ($urandom_range(1) == 1) begin
            n = ($urandom_range(7) == 0) ? $urandom_range(1, 128)
                                         : $urandom_range(1, (left < 127) ? left + 1 : 128);
            append_byte(8'(RAW_MAX + n));
            add_pixels(1, nbytes);
         end else begin
            n = $urandom_range(1, (left < 126) ? left + 2 : 128);
            append_byte(8'(n - 1));
            add_pixels(n, nbytes);
         end
         left = left - n;
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_header_faults();
      // size and depth faults at once: zero size reported; trailing bytes dropped
      build_header(TYPE_RAW, 16'h0000, 16'hFFFF, 8'd0);
      add_junk(2);
      send_file();
      // bad type, file ends on the last header byte
      build_header(8'hFF, 16'hFFFF, 16'd1, 8'd32);
      send_file();
      // bad depth
      build_header(TYPE_RLE, 16'd1, 16'd1, 8'd16);
      add_junk(1);
      send_file();
   endtask

   task automatic test_raw_image();
      // white then black BGR pixel, bytes after the image are ignored
      build_header(TYPE_RAW, 16'd2, 16'd1, 8'd24);
      repeat (3) append_byte(8'hFF);
      repeat (3) append_byte(8'h00);
      add_junk(3);
      send_file();
   endtask

   task automatic test_rle_image();
      // single run, then a 128 run clipped to the two missing pixels
      build_header(TYPE_RLE, 16'd3, 16'd1, 8'd32);
      append_byte(8'h80);
      add_pixels(1, 4);
      append_byte(8'hFF);
      add_pixels(1, 4);
      send_file();
   endtask

   task automatic test_raw_packet_overrun();
      // raw packet of 128 on a two-pixel image stops after the second pixel
      build_header(TYPE_RLE, 16'd1, 16'd2, 8'd24);
      append_byte(RAW_MAX);
      add_pixels(3, 3);
      send_file();
   endtask

   task automatic test_truncation();
      // end inside the header
      build_header(TYPE_RAW, 16'd1, 16'd1, 8'd24);
      file_bytes = file_bytes[0:5];
      send_file();
      // end right after a valid header
      build_header(TYPE_RAW, 16'd1, 16'd1, 8'd24);
      send_file();
      // end in the middle of a pixel
      build_header(TYPE_RAW, 16'd2, 16'd2, 8'd24);
      add_pixels(1, 3);
      add_junk(2);
      send_file();
      // end on the byte completing a run that leaves the image short
      build_header(TYPE_RLE, 16'd2, 16'd2, 8'd24);
      append_byte(8'h81);
      add_pixels(1, 3);
      send_file();
   endtask

   task automatic test_backpressure();
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b0;
      build_header(TYPE_RAW, 16'd4, 16'd4, 8'd24);
      add_pixels(16, 3);
      hold_request++;
      send_file();
      await_results();
      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;
   endtask

   task automatic test_random_files(input int byte_budget);
      int              sent;
      int              sel;
      int              nbytes;
      int              npix;
      longint unsigned total;
      logic [7:0]      kind_byte;
      logic [7:0]      depth;
      logic [15:0]     w;
      logic [15:0]     h;
      bit              good;
      sent = 0;
      while (sent < byte_budget) begin
         // first third runs without any idling on either side
         sender_gaps   = (sent > byte_budget / 3);
         receiver_gaps = (sent > byte_budget / 3);
         kind_byte = ($urandom_range(1) == 1) ? TYPE_RAW : TYPE_RLE;
         depth     = 8'($urandom_range(24, 39));
         w         = 16'($urandom_range(1, 5));
         h         = 16'($urandom_range(1, 5));
         sel       = $urandom_range(99);
         if (sel < 8) begin
            w = ($urandom_range(1) == 1) ? 16'd0 : 16'($urandom_range(65535));
            h = (w == 16'd0) ? 16'($urandom_range(65535)) : 16'd0;
         end else if (sel < 16) begin
            kind_byte = 8'($urandom_range(255));
         end else if (sel < 24) begin
            depth = 8'($urandom_range(255));
         end else if (sel < 32) begin
            // large image: the file mostly ends early
            w = 16'($urandom_range(1, 65535));
            h = 16'($urandom_range(9, 65535));
         end
         build_header(kind_byte, w, h, depth);
         nbytes = int'(depth[7:3]);
         good   = w != 16'd0 && h != 16'd0 && (nbytes == 3 || nbytes == 4) &&
                  (kind_byte == TYPE_RAW || kind_byte == TYPE_RLE);
         if (good) begin
            total = longint'(w) * h;
            npix  = (total > 40) ? 40 : int'(total);
            if (kind_byte == TYPE_RAW)
               add_pixels(npix, nbytes);
            else
               add_rle_packets(npix, nbytes);
         end else begin
            add_junk($urandom_range(4));
         end
         sel = $urandom_range(99);
         if (sel < 15)
            file_bytes = file_bytes[0:$urandom_range(file_bytes.size() - 1)];
         else if (sel < 30)
            add_junk($urandom_range(1, 4));
         send_file();
         sent = sent + file_bytes.size();
      end
      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data_byte   = 8'h00;
      req_end_of_file = 1'b0;
      clear_decoder();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_header_faults();
      test_raw_image();
      test_rle_image();
      test_raw_packet_overrun();
      test_truncation();
      await_results();
      test_backpressure();
      test_random_files(380);
      await_results();
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
